// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the frame receiver.
// Each macro compiles to a concurrent assertion in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication within the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication into the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/bfrf_pkg.sv =====
// Package of the frame receiver: field widths, protocol constants and codes.
// Used by the channel interfaces and by the top level; depends on nothing.
package bfrf_pkg;

	localparam int unsigned BUFFER_BYTES_DEF = 1024;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned LEN_W    = 16;
	localparam int unsigned IDX_W    = 10;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
	localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_CLASS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_ID    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_EN   = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_CSUM    = 2'd1,
		ST_TYPE    = 2'd2,
		ST_LEN     = 2'd3
	} status_t;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	typedef enum logic [5:0] {
		PH_HUNT1   = 6'b000001,
		PH_HUNT2   = 6'b000010,
		PH_HEADER  = 6'b000100,
		PH_PAYLOAD = 6'b001000,
		PH_CHECK_A = 6'b010000,
		PH_CHECK_B = 6'b100000
	} phase_t;

	// Header byte positions after the sync pair.
	typedef enum logic [1:0] {
		HDR_CLASS = 2'd0,
		HDR_ID    = 2'd1,
		HDR_LEN_L = 2'd2,
		HDR_LEN_H = 2'd3
	} hdr_pos_t;

endpackage

// ===== rtl/core/bfrf_chan_if.sv =====
// Valid/ready channel interfaces of the frame receiver: received bytes, results
// and configuration writes. Depends on bfrf_pkg.
interface bfrf_rx_if;
	logic                           valid;
	logic                           ready;
	logic [bfrf_pkg::BYTE_W-1:0]    rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface bfrf_res_if;
	logic                             valid;
	logic                             ready;
	logic                             out_kind;
	logic [bfrf_pkg::BYTE_W-1:0]      data_byte;
	logic [bfrf_pkg::IDX_W-1:0]       byte_index;
	logic [bfrf_pkg::BYTE_W-1:0]      msg_class;
	logic [bfrf_pkg::BYTE_W-1:0]      msg_ident;
	logic [bfrf_pkg::LEN_W-1:0]       payload_length;
	logic [bfrf_pkg::STATUS_W-1:0]    frame_status;
	logic [bfrf_pkg::BYTE_W-1:0]      rx_check_a;
	logic [bfrf_pkg::BYTE_W-1:0]      rx_check_b;
	logic                             last;

	modport source (output valid, output out_kind, output data_byte, output byte_index,
		output msg_class, output msg_ident, output payload_length, output frame_status,
		output rx_check_a, output rx_check_b, output last, input ready);
	modport sink (input valid, input out_kind, input data_byte, input byte_index,
		input msg_class, input msg_ident, input payload_length, input frame_status,
		input rx_check_a, input rx_check_b, input last, output ready);
endinterface

interface bfrf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [bfrf_pkg::CFG_IDX_W-1:0]    index;
	logic [bfrf_pkg::BYTE_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/binary_frame_receiver_fletcher_unit.sv =====
// Frame receiver with sync hunt, header capture and 8-bit Fletcher check.
// Depends on bfrf_pkg, the interfaces in bfrf_chan_if.sv and assert_macros.svh.

// The receiver takes one byte per transaction and can accept a byte in every
// cycle: the whole parse step for a byte runs between the state registers and a
// single result register, and a new byte is taken whenever that register is
// empty or its result is being taken in the same cycle. A result is registered
// and appears in the cycle after the byte that causes it. Each payload byte yields a result with
// its index; after the second checksum byte a frame end result reports ok,
// checksum mismatch or unexpected class/id (a checksum mismatch wins). A frame
// whose declared length plus two checksum bytes exceeds BUFFER_BYTES yields a
// length-too-long end result straight after the length and the hunt restarts.
// Configuration writes are always taken; index 3 is ignored.
`include "assert_macros.svh"

module binary_frame_receiver_fletcher_unit #(
	parameter int unsigned BUFFER_BYTES = bfrf_pkg::BUFFER_BYTES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	bfrf_rx_if.sink      rx,
	bfrf_res_if.source   res,
	bfrf_cfg_if.sink     cfg
);
	import bfrf_pkg::*;

	localparam int unsigned CW = $clog2(BUFFER_BYTES);

	// Configuration registers.
	logic [BYTE_W-1:0] exp_class_q;
	logic [BYTE_W-1:0] exp_id_q;
	logic              type_en_q;

	// Parser state.
	phase_t            phase_q, phase_d;
	hdr_pos_t          hdr_q, hdr_d;
	logic [BYTE_W-1:0] class_q, class_d;
	logic [BYTE_W-1:0] ident_q, ident_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [CW-1:0]     cnt_q, cnt_d;
	logic [CW:0]       cnt_inc;
	logic [BYTE_W-1:0] sum_a_q, sum_a_d, sum_a_add;
	logic [BYTE_W-1:0] sum_b_q, sum_b_d, sum_b_add;
	logic [BYTE_W-1:0] chk_a_q, chk_a_d;

	// Result computed for the current byte.
	logic              emit;
	logic              kind_d;
	logic [BYTE_W-1:0] data_d;
	status_t           status_d;
	logic [BYTE_W-1:0] rca_d, rcb_d;

	// Result register.
	logic              valid_s1;
	logic              kind_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [BYTE_W-1:0] class_s1, ident_s1;
	logic [LEN_W-1:0]  len_s1;
	status_t           status_s1;
	logic [BYTE_W-1:0] rca_s1, rcb_s1;

	logic rx_fire;
	logic [BYTE_W-1:0] b;

	assign rx.ready  = !valid_s1 || res.ready;
	assign rx_fire   = rx.valid && rx.ready;
	assign b         = rx.rx_byte;
	assign cfg.ready = 1'b1;

	assign sum_a_add = sum_a_q + b;
	assign sum_b_add = sum_b_q + sum_a_add;
	assign cnt_inc   = (CW+1)'(cnt_q) + (CW+1)'(1);

	always_comb begin
		phase_d  = phase_q;
		hdr_d    = hdr_q;
		class_d  = class_q;
		ident_d  = ident_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		sum_a_d  = sum_a_q;
		sum_b_d  = sum_b_q;
		chk_a_d  = chk_a_q;
		emit     = 1'b0;
		kind_d   = KIND_PAYLOAD;
		data_d   = '0;
		status_d = ST_OK;
		rca_d    = '0;
		rcb_d    = '0;
		case (phase_q)
			PH_HUNT1: begin
				if (b == SYNC_FIRST)
					phase_d = PH_HUNT2;
			end
			PH_HUNT2: begin
				if (b == SYNC_SECOND) begin
					phase_d = PH_HEADER;
					hdr_d   = HDR_CLASS;
					cnt_d   = '0;
					sum_a_d = '0;
					sum_b_d = '0;
				end else if (b != SYNC_FIRST) begin
					phase_d = PH_HUNT1;
				end
			end
			PH_HEADER: begin
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_add;
				case (hdr_q)
					HDR_CLASS: begin
						class_d = b;
						hdr_d   = HDR_ID;
					end
					HDR_ID: begin
						ident_d = b;
						hdr_d   = HDR_LEN_L;
					end
					HDR_LEN_L: begin
						len_d = {8'h00, b};
						hdr_d = HDR_LEN_H;
					end
					HDR_LEN_H: begin
						len_d = {b, len_q[7:0]};
						hdr_d = HDR_CLASS;
						cnt_d = '0;
						if (32'(len_d) + 32'd2 > 32'(BUFFER_BYTES)) begin
							phase_d  = PH_HUNT1;
							emit     = 1'b1;
							kind_d   = KIND_END;
							status_d = ST_LEN;
						end else if (len_d == '0) begin
							phase_d = PH_CHECK_A;
						end else begin
							phase_d = PH_PAYLOAD;
						end
					end
					default: hdr_d = HDR_CLASS;
				endcase
			end
			PH_PAYLOAD: begin
				sum_a_d = sum_a_add;
				sum_b_d = sum_b_add;
				emit    = 1'b1;
				data_d  = b;
				cnt_d   = cnt_inc[CW-1:0];
				if (32'(cnt_inc) >= 32'(len_q))
					phase_d = PH_CHECK_A;
			end
			PH_CHECK_A: begin
				chk_a_d = b;
				phase_d = PH_CHECK_B;
			end
			PH_CHECK_B: begin
				if (chk_a_q != sum_a_q || b != sum_b_q)
					status_d = ST_CSUM;
				else if (type_en_q && (class_q != exp_class_q || ident_q != exp_id_q))
					status_d = ST_TYPE;
				else
					status_d = ST_OK;
				phase_d = PH_HUNT1;
				emit    = 1'b1;
				kind_d  = KIND_END;
				rca_d   = chk_a_q;
				rcb_d   = b;
			end
			default: phase_d = PH_HUNT1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_class_q <= '0;
			exp_id_q    <= '0;
			type_en_q   <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_EXP_CLASS: exp_class_q <= cfg.data;
				CFG_EXP_ID:    exp_id_q    <= cfg.data;
				CFG_TYPE_EN:   type_en_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT1;
			hdr_q   <= HDR_CLASS;
			class_q <= '0;
			ident_q <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
			chk_a_q <= '0;
		end else if (rx_fire) begin
			phase_q <= phase_d;
			hdr_q   <= hdr_d;
			class_q <= class_d;
			ident_q <= ident_d;
			len_q   <= len_d;
			cnt_q   <= cnt_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			chk_a_q <= chk_a_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (rx_fire)
			valid_s1 <= emit;
		else if (res.ready)
			valid_s1 <= 1'b0;
	end

	// The payload index is taken from the counter before it advances.
	always_ff @(posedge clk) begin
		if (rx_fire && emit) begin
			kind_s1   <= kind_d;
			data_s1   <= data_d;
			idx_s1    <= (kind_d == KIND_PAYLOAD) ? IDX_W'(cnt_q) : '0;
			class_s1  <= class_d;
			ident_s1  <= ident_d;
			len_s1    <= len_d;
			status_s1 <= status_d;
			rca_s1    <= rca_d;
			rcb_s1    <= rcb_d;
		end
	end

	assign res.valid          = valid_s1;
	assign res.out_kind       = kind_s1;
	assign res.data_byte      = data_s1;
	assign res.byte_index     = idx_s1;
	assign res.msg_class      = class_s1;
	assign res.msg_ident      = ident_s1;
	assign res.payload_length = len_s1;
	assign res.frame_status   = status_s1;
	assign res.rx_check_a     = rca_s1;
	assign res.rx_check_b     = rcb_s1;
	assign res.last           = kind_s1;

	`ASSERT_NEXT(a_end_after_check_b, clk, arst_n, rx_fire && phase_q == PH_CHECK_B, valid_s1 && kind_s1 == KIND_END, "second checksum byte gave no frame end result")
	`ASSERT_SAME(a_index_in_frame, clk, arst_n, valid_s1 && kind_s1 == KIND_PAYLOAD, 32'(idx_s1) < 32'(len_s1), "payload index not below declared length")
	`ASSERT_SAME(a_payload_status, clk, arst_n, valid_s1 && kind_s1 == KIND_PAYLOAD, status_s1 == ST_OK && rca_s1 == '0 && rcb_s1 == '0, "payload result carries end report fields")
	`ASSERT_SAME(a_len_report, clk, arst_n, valid_s1 && status_s1 == ST_LEN, kind_s1 == KIND_END && 32'(len_s1) + 32'd2 > 32'(BUFFER_BYTES), "length report on a frame that fits")
	`ASSERT_NEXT(a_hunt_after_end, clk, arst_n, rx_fire && emit && kind_d == KIND_END, phase_q == PH_HUNT1, "parser did not return to the hunt after a frame end")

endmodule
